// ===== design/et_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// et_pkg
// Shared types and constants for the totient block.
// ----------------------------------------------------------------------------
package et_pkg;

    localparam int VALUE_BITS_DEF = 26;
    localparam int FIELD_W        = 26;
    localparam int TDATA_W        = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_DIV,
        ST_CHECK,
        ST_FINAL
    } state_t;

endpackage

// ===== design/euler_totient_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_totient_top
// Euler's totient by trial division, bit-serial divider under a sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)       | tuser
//  s_      | in  | value_in[25:0], zeros    | -
//  m_      | out | totient[25:0], zeros     | bad_input
//
//  Divisors run 2, 3, 5, 7, ... until d*d exceeds the remaining value.
//  Each divisor is tried with ST_SQUARE, ST_DIV and ST_CHECK in the shared
//  restoring divider, and after a hit ST_CHECK goes back to ST_DIV; zero is
//  answered straight from idle.
//  Synchronous active-low reset clears the sequencer and output valid.
//  s_tready stays low from acceptance until the result has been taken.
// ----------------------------------------------------------------------------
module euler_totient_top #(
    parameter int VALUE_BITS = et_pkg::VALUE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [et_pkg::TDATA_W-1:0] s_tdata,   // value_in[25:0], zeros
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [et_pkg::TDATA_W-1:0] m_tdata,   // totient[25:0], zeros
    output logic                       m_tuser    // bad_input
);

    localparam int VB = VALUE_BITS;
    localparam int DW = VB / 2 + 2;
    localparam int CW = $clog2(VB + 1);

    et_pkg::state_t state_reg, state_next;

    logic [VB-1:0] rem_reg, rem_next;
    logic [VB-1:0] phi_reg, phi_next;
    logic [DW-1:0] d_reg, d_next;
    logic          hit_reg, hit_next;
    logic [VB-1:0] num_reg, num_next;
    logic [VB-1:0] quo_reg, quo_next;
    logic [VB:0]   acc_reg, acc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          mval_reg, mval_next;
    logic [VB-1:0] tot_reg, tot_next;
    logic          bad_reg, bad_next;

    logic [VB-1:0]   value_in;
    logic [2*DW-1:0] d_sq;
    logic [VB:0]     shifted;
    logic [VB:0]     d_ext;
    logic [VB-1:0]   mul_op;
    logic [2*VB-1:0] product;

    assign value_in = s_tdata[VB-1:0];
    assign d_sq     = d_reg * d_reg;
    assign shifted  = {acc_reg[VB-1:0], num_reg[VB-1]};
    assign d_ext    = (VB + 1)'(d_reg);
    assign product  = phi_reg * mul_op;

    assign s_tready = (state_reg == et_pkg::ST_IDLE) && !mval_reg;
    assign m_tvalid = mval_reg;
    assign m_tdata  = et_pkg::TDATA_W'(tot_reg);
    assign m_tuser  = bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= et_pkg::ST_IDLE;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
        rem_reg <= rem_next;
        phi_reg <= phi_next;
        d_reg   <= d_next;
        hit_reg <= hit_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
        tot_reg <= tot_next;
        bad_reg <= bad_next;
    end

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        phi_next   = phi_reg;
        d_next     = d_reg;
        hit_next   = hit_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        mval_next  = mval_reg;
        tot_next   = tot_reg;
        bad_next   = bad_reg;
        mul_op     = VB'(d_reg);

        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end

        case (state_reg)
            et_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (value_in == '0) begin
                        tot_next  = '0;
                        bad_next  = 1'b1;
                        mval_next = 1'b1;
                    end else begin
                        rem_next   = value_in;
                        phi_next   = VB'(1);
                        d_next     = DW'(2);
                        hit_next   = 1'b0;
                        state_next = et_pkg::ST_SQUARE;
                    end
                end
            end
            et_pkg::ST_SQUARE: begin
                if (d_sq > (2 * DW)'(rem_reg)) begin
                    state_next = et_pkg::ST_FINAL;
                end else begin
                    num_next   = rem_reg;
                    quo_next   = '0;
                    acc_next   = '0;
                    cnt_next   = CW'(VB);
                    state_next = et_pkg::ST_DIV;
                end
            end
            et_pkg::ST_DIV: begin
                num_next = {num_reg[VB-2:0], 1'b0};
                if (shifted >= d_ext) begin
                    acc_next = shifted - d_ext;
                    quo_next = {quo_reg[VB-2:0], 1'b1};
                end else begin
                    acc_next = shifted;
                    quo_next = {quo_reg[VB-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = et_pkg::ST_CHECK;
                end
            end
            et_pkg::ST_CHECK: begin
                // first hit of a prime scales by p-1, further hits by p
                mul_op = hit_reg ? VB'(d_reg) : VB'(d_reg - DW'(1));
                if (acc_reg == '0) begin
                    rem_next   = quo_reg;
                    phi_next   = product[VB-1:0];
                    hit_next   = 1'b1;
                    num_next   = quo_reg;
                    quo_next   = '0;
                    cnt_next   = CW'(VB);
                    state_next = et_pkg::ST_DIV;
                end else begin
                    d_next     = (d_reg == DW'(2)) ? DW'(3) : d_reg + DW'(2);
                    hit_next   = 1'b0;
                    state_next = et_pkg::ST_SQUARE;
                end
            end
            et_pkg::ST_FINAL: begin
                mul_op = rem_reg - VB'(1);
                if (rem_reg > VB'(1)) begin
                    tot_next = product[VB-1:0];
                end else begin
                    tot_next = phi_reg;
                end
                bad_next   = 1'b0;
                mval_next  = 1'b1;
                state_next = et_pkg::ST_IDLE;
            end
            default: begin
                state_next = et_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/et_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// et_checker
// Port-level checks for the totient block, bound to the top level.
// ----------------------------------------------------------------------------
module et_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [et_pkg::TDATA_W-1:0] s_tdata,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [et_pkg::TDATA_W-1:0] m_tdata,
    input logic                       m_tuser
);

    // zero input flags an error with a zero totient
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("bad_input with non-zero totient");

    // one transaction in flight at a time
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready straight after acceptance");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind euler_totient_top et_checker u_et_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for euler_totient_top. Numbers are streamed in through
// the slave channel and every totient that comes back is checked against a
// trial-division predictor, with random gaps on both sides and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int FW             = et_pkg::FIELD_W;
    localparam int TW             = et_pkg::TDATA_W;

    typedef struct packed {
        logic [FW-1:0] totient;
        logic          bad_input;
    } totient_res_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [TW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [TW-1:0] m_tdata;
    logic          m_tuser;

    logic [FW-1:0] numbers_q[$];
    totient_res_t  totients_q[$];
    int            sent_cnt = 0;
    int            got_cnt = 0;
    int            hold_cnt = 0;
    int            quiet_cnt = 0;
    int            total_items = 0;
    bit            failed = 1'b0;

    euler_totient_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic totient_res_t calc_totient(logic [FW-1:0] n);
        totient_res_t r;
        longint unsigned rest;
        longint unsigned phi;
        longint unsigned d;
        longint unsigned pk;
        rest = n;
        phi  = 1;
        d    = 2;
        r.bad_input = (n == 0);
        if (n == 0) begin
            r.totient = '0;
            return r;
        end
        while (d * d <= rest) begin
            pk = 1;
            while (rest % d == 0) begin
                rest = rest / d;
                pk   = pk * d;
            end
            if (pk > 1)
                phi = phi * (pk - pk / d);
            d = (d == 2) ? 3 : d + 2;
        end
        if (rest > 1)
            phi = phi * (rest - 1);
        r.totient = phi[FW-1:0];
        return r;
    endfunction

    // driver; no gaps for transactions 30..54
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                totients_q.push_back(calc_totient(s_tdata[FW-1:0]));
                sent_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (numbers_q.size() > 0 &&
                    ((sent_cnt >= 30 && sent_cnt < 55) || $urandom_range(0, 99) >= 31)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(TW-FW){1'b0}}, numbers_q.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor; long hold-off after the tenth result, no gaps for 30..54
    always @(posedge aclk) begin
        totient_res_t exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (totients_q.size() == 0) begin
                    $error("unexpected result: totient %0d", m_tdata[FW-1:0]);
                    failed = 1'b1;
                end else begin
                    exp_r = totients_q.pop_front();
                    if (m_tdata[FW-1:0] !== exp_r.totient) begin
                        $error("totient: expected %0d, actual %0d",
                               exp_r.totient, m_tdata[FW-1:0]);
                        failed = 1'b1;
                    end
                    if (m_tdata[TW-1:FW] !== '0) begin
                        $error("tdata padding: expected 0, actual %0h",
                               m_tdata[TW-1:FW]);
                        failed = 1'b1;
                    end
                    if (m_tuser !== exp_r.bad_input) begin
                        $error("bad_input: expected %0b, actual %0b", exp_r.bad_input, m_tuser);
                        failed = 1'b1;
                    end
                end
                got_cnt++;
                if (got_cnt == 10)
                    hold_cnt = 600;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (got_cnt >= 30 && got_cnt < 55) || $urandom_range(0, 99) >= 31;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int pick;
        numbers_q = '{0, 1, 2, 3, 4, 6, 12, 97, 128, 210, 1024, 9973, 65536, 30030,
                      26'h3FFFFFF, 26'h2AAAAAA, 26'h1555555,
                      67108859, 67092481, 33554432, 9999991};
        repeat (80) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                numbers_q.push_back(FW'($urandom_range(0, 16383)));
            else if (pick < 95)
                numbers_q.push_back(FW'($urandom_range(0, 262143)));
            else
                numbers_q.push_back(FW'($urandom_range(0, 26'h3FFFFFF)));
        end
        total_items = numbers_q.size();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait (got_cnt == total_items);
        repeat (100) @(posedge aclk);
        if (!failed && totients_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
